// ===== design/eph_pkg.sv =====
// eph_pkg: shared types and constants for the ADC entropy pool harvester.
// No dependencies. Used by eph_cell, the top level and the checker.
`timescale 1ns / 1ps

package eph_pkg;

    // Fixed field widths
    localparam int WORD_W    = 16;  // pool word
    localparam int SAMPLE_W  = 10;  // ADC conversion result
    localparam int BYTE_W    = 8;   // harvested byte
    localparam int CFG_W     = 16;  // request length register
    localparam int IN_DATA_W = 16;  // sample padded to whole bytes

    // Samples folded per pool word in one round
    localparam int ROUND_PER_WORD = 16;

    // Input item kinds carried on tuser
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic
    {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

// ===== design/eph_cell.sv =====
// eph_cell: one pool word of the harvester's shift ring.
// Depends on eph_pkg for the word width.
`timescale 1ns / 1ps

module eph_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      shift,
    input  logic [eph_pkg::WORD_W-1:0] d_in,
    output logic [eph_pkg::WORD_W-1:0] q
);
    import eph_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (clear)
        begin
            word_next = '0;
        end
        else if (shift)
        begin
            word_next = d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

// ===== design/adc_entropy_pool_harvester_unit.sv =====
// adc_entropy_pool_harvester_unit: top level of the ADC entropy pool harvester.
// Depends on eph_pkg and eph_cell.
`timescale 1ns / 1ps

// Folds 10-bit ADC noise samples into a pool of POOL_WORDS 16-bit words and
// hands out the pool as random bytes. A start item (tuser = 0) clears the
// pool, loads the byte count from the request_bytes register (cfg port) and
// arms the block; a sample item (tuser = 1) rotates the current word left by
// ROTATE_AMOUNT and XORs in the sample, words taken round-robin. After
// 16*POOL_WORDS samples the pool goes out as up to 2*POOL_WORDS bytes, word 0
// first, low byte first, cut short when the request runs out; tlast marks the
// last byte of a burst and tuser marks the byte that completes the request.
// Samples while not armed are dropped. The input accepts one item per cycle
// while collecting. The pool is a ring of cells that shifts by one word per
// sample (and per two bytes on emission), so the word being worked on always
// sits in cell 0. The burst after a full round holds off the input until its
// last byte is loaded into the output register, so any stall on the output
// lengthens it; the single output register lets the next item in while the
// last byte still waits to be taken.
module adc_entropy_pool_harvester_unit
#(
    parameter int POOL_WORDS    = 8,   // 1 .. 16
    parameter int ROTATE_AMOUNT = 5    // 1 .. 15
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration: request_bytes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eph_pkg::CFG_W-1:0]     cfg_data,

    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [eph_pkg::IN_DATA_W-1:0] s_tdata,   // [9:0] sample, [15:10] zero
    input  logic                          s_tuser,   // [0] action

    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [eph_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,   // last_of_run
    output logic                          m_tuser    // [0] request_done
);
    import eph_pkg::*;

    localparam int ROUND_SAMPLES = ROUND_PER_WORD * POOL_WORDS;
    localparam int CNT_W         = $clog2(ROUND_SAMPLES);
    localparam int BIDX_W        = $clog2(2 * POOL_WORDS);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(ROUND_SAMPLES - 1);
    localparam logic [BIDX_W-1:0] LAST_BIDX = BIDX_W'(2 * POOL_WORDS - 1);

    // control state
    state_t              state_reg, state_next;
    logic                running_reg, running_next;
    logic [CFG_W-1:0]    req_reg, req_next;
    logic [CFG_W-1:0]    left_reg, left_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BIDX_W-1:0]   bidx_reg, bidx_next;

    // output register
    logic                ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]   obyte_reg, obyte_next;
    logic                olast_reg, olast_next;
    logic                odone_reg, odone_next;

    // ring
    logic [WORD_W-1:0]   word_q [POOL_WORDS];
    logic [WORD_W-1:0]   head;
    logic [WORD_W-1:0]   folded;
    logic [WORD_W-1:0]   feedback;
    logic                ring_clear;
    logic                ring_shift;

    // handshakes and events
    logic                in_fire;
    logic                is_start;
    logic                is_sample;
    logic                round_end;
    logic                out_free;
    logic                emit_fire;
    logic                emit_done;   // byte that completes the request
    logic                emit_last;   // last byte of this burst

    assign cfg_ready = 1'b1;

    assign in_fire   = s_tvalid & s_tready;
    assign is_start  = in_fire & (s_tuser == ACT_START);
    assign is_sample = in_fire & (s_tuser == ACT_SAMPLE) & running_reg;
    assign round_end = is_sample & (cnt_reg == LAST_CNT);

    assign out_free  = ~ovalid_reg | m_tready;
    assign emit_fire = (state_reg == ST_EMIT) & out_free;
    assign emit_done = (left_reg == CFG_W'(1));
    assign emit_last = emit_fire & (emit_done | (bidx_reg == LAST_BIDX));

    // fold: rotate the head word left and mix in the sample
    assign head   = word_q[0];
    assign folded = {head[WORD_W-1-ROTATE_AMOUNT:0], head[WORD_W-1:WORD_W-ROTATE_AMOUNT]}
                    ^ {{(WORD_W - SAMPLE_W){1'b0}}, s_tdata[SAMPLE_W-1:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (round_end && (left_reg != '0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // state-dependent outputs and ring control
    always_comb
    begin
        s_tready   = 1'b0;
        ring_clear = 1'b0;
        ring_shift = 1'b0;
        feedback   = head;
        unique case (state_reg)
            ST_COLLECT:
            begin
                s_tready   = 1'b1;
                ring_clear = is_start;
                ring_shift = is_sample;
                feedback   = folded;
            end
            ST_EMIT:
            begin
                // advance one word after its high byte goes out
                ring_shift = emit_fire & bidx_reg[0];
                feedback   = head;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // counters, request bookkeeping, output register
    always_comb
    begin
        running_next = running_reg;
        req_next     = req_reg;
        left_next    = left_reg;
        cnt_next     = cnt_reg;
        bidx_next    = bidx_reg;
        ovalid_next  = ovalid_reg & ~m_tready;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;
        odone_next   = odone_reg;

        if (cfg_valid && cfg_ready)
        begin
            req_next = cfg_data;
        end

        if (is_start)
        begin
            running_next = 1'b1;
            left_next    = req_reg;
            cnt_next     = '0;
        end
        else if (is_sample)
        begin
            cnt_next = round_end ? '0 : cnt_reg + CNT_W'(1);
            // zero-byte request: one round, then idle with nothing emitted
            if (round_end && (left_reg == '0))
            begin
                running_next = 1'b0;
            end
        end

        if (emit_fire)
        begin
            ovalid_next = 1'b1;
            obyte_next  = bidx_reg[0] ? head[WORD_W-1:BYTE_W] : head[BYTE_W-1:0];
            olast_next  = emit_done | (bidx_reg == LAST_BIDX);
            odone_next  = emit_done;
            left_next   = left_reg - CFG_W'(1);
            bidx_next   = emit_last ? '0 : bidx_reg + BIDX_W'(1);
            if (emit_done)
            begin
                running_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            running_reg <= 1'b0;
            req_reg     <= '0;
            left_reg    <= '0;
            cnt_reg     <= '0;
            bidx_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            req_reg     <= req_next;
            left_reg    <= left_next;
            cnt_reg     <= cnt_next;
            bidx_reg    <= bidx_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
    end

    // ring of pool cells: cell i takes cell i+1, the tail takes the feedback word
    for (genvar i = 0; i < POOL_WORDS; i++)
    begin : g_cell
        logic [WORD_W-1:0] d_in;
        if (i == POOL_WORDS - 1)
        begin : g_tail
            assign d_in = feedback;
        end
        else
        begin : g_body
            assign d_in = word_q[i+1];
        end

        eph_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (ring_clear),
            .shift (ring_shift),
            .d_in  (d_in),
            .q     (word_q[i])
        );
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = odone_reg;

endmodule

// ===== design/eph_checker.sv =====
// eph_checker: port-level assertions for adc_entropy_pool_harvester_unit.
// Depends on eph_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps

module eph_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [eph_pkg::BYTE_W-1:0]    m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);
    import eph_pkg::*;

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // the byte that finishes a request also ends the burst
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("request_done without last_of_run");

    // input stays blocked while a burst is still going out
    a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a burst");

    // a start item produces no byte
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_START) |=> !$rose(m_tvalid))
        else $error("byte produced by a start item");

endmodule

bind adc_entropy_pool_harvester_unit eph_checker u_eph_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/tb_adc_entropy_pool_harvester_unit.sv =====
// tb_adc_entropy_pool_harvester_unit: self-checking testbench for the ADC entropy pool harvester.
// Depends on eph_pkg and adc_entropy_pool_harvester_unit; carries its own pool predictor.
`timescale 1ns / 1ps

module tb_adc_entropy_pool_harvester_unit;

    import eph_pkg::*;

    localparam int POOL_N     = 8;
    localparam int ROT        = 5;
    localparam int ROUND_LEN  = ROUND_PER_WORD * POOL_N;  // samples per round
    localparam int BURST_LEN  = 2 * POOL_N;               // bytes per full burst
    localparam int SETTLE_CYC = BURST_LEN + 8;            // quiet time after last byte

    // one harvested byte as seen on the master side
    typedef struct packed
    {
        logic [BYTE_W-1:0] data_byte;
        logic              run_last;
        logic              req_done;
    } harvest_byte_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;   // [9:0] sample, [15:10] zero
    logic                 s_tuser   = 1'b0; // [0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;          // [7:0] out_byte
    logic                 m_tlast;
    logic                 m_tuser;          // [0] request_done

    // predictor state: mirror of the pool, round counter and request bookkeeping
    logic [WORD_W-1:0] pool_words [POOL_N];
    int                fold_count      = 0;
    logic [CFG_W-1:0]  bytes_remaining = '0;
    logic              armed           = 1'b0;
    logic [CFG_W-1:0]  request_len     = '0;

    harvest_byte_t expected_bytes [$];
    int            bytes_predicted = 0;
    int            mismatch_count  = 0;

    // per-phase idle and stall odds, in percent
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    adc_entropy_pool_harvester_unit
    #(
        .POOL_WORDS    (POOL_N),
        .ROTATE_AMOUNT (ROT)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < POOL_N; i++)
            pool_words[i] = '0;
    end

    // Fold one accepted item into the mirrored pool; at round end queue the burst.
    function automatic void fold_item(input logic act, input logic [SAMPLE_W-1:0] smp);
        int            slot;
        int            b;
        logic [WORD_W-1:0] w;
        harvest_byte_t hb;
        if (act == ACT_START)
        begin
            for (slot = 0; slot < POOL_N; slot++)
                pool_words[slot] = '0;
            fold_count      = 0;
            bytes_remaining = request_len;
            armed           = 1'b1;
            return;
        end
        if (!armed)
            return;     // sample while idle is dropped
        slot = fold_count % POOL_N;
        w    = pool_words[slot];
        pool_words[slot] = ((w << ROT) | (w >> (WORD_W - ROT))) ^ WORD_W'(smp);
        fold_count++;
        if (fold_count < ROUND_LEN)
            return;
        // burst: word 0 first, low byte first, cut short when the request runs dry
        for (b = 0; b < BURST_LEN && bytes_remaining != 0; b++)
        begin
            w = pool_words[b / 2];
            hb.data_byte    = (b % 2 == 1) ? w[15:8] : w[7:0];
            bytes_remaining = bytes_remaining - 1'b1;
            hb.req_done     = (bytes_remaining == 0);
            hb.run_last     = (b == BURST_LEN - 1) || (bytes_remaining == 0);
            expected_bytes.push_back(hb);
            bytes_predicted++;
        end
        if (bytes_remaining == 0)
            armed = 1'b0;
        else
            fold_count = 0;     // pool carries over into the next round
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Output side: random backpressure, one NBA per edge.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Compare every accepted byte against the oldest queued prediction.
    always @(posedge clk)
    begin : check_bytes
        harvest_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("byte with nothing expected", m_tdata, 0);
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data_byte)
                    report_mismatch("out_byte", m_tdata, want.data_byte);
                if (m_tlast !== want.run_last)
                    report_mismatch("last_of_run", m_tlast, want.run_last);
                if (m_tuser !== want.req_done)
                    report_mismatch("request_done", m_tuser, want.req_done);
            end
        end
    end

    // One input item: optional idle gap, then hold until the handshake.
    task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(IN_DATA_W - SAMPLE_W){1'b0}}, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fold_item(act, smp);
    endtask

    // Drop valid, wait for every predicted byte, then let a final fold settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_request(input logic [CFG_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        request_len = len;
    endtask

    // ADC-like noise with the rails hit now and then
    function automatic logic [SAMPLE_W-1:0] noise_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_request();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;                       // 65535, never finishes here
            2:       return CFG_W'(BURST_LEN);        // exactly one burst
            3:       return CFG_W'(2 * BURST_LEN);    // ends on a round boundary
            default: return CFG_W'($urandom_range(1, 48));
        endcase
    endfunction

    task automatic send_round(input int count);
        repeat (count) send_item(ACT_SAMPLE, noise_sample());
    endtask

    // Nothing armed after reset: samples, rails and checkerboards alike, vanish.
    task automatic test_ignored_samples();
        send_item(ACT_SAMPLE, '0);
        send_item(ACT_SAMPLE, '1);
        send_item(ACT_SAMPLE, 10'h2AA);
        send_item(ACT_SAMPLE, 10'h155);
        drain_results();
    endtask

    // Zero-byte request still folds a full round, emits nothing, goes idle.
    task automatic test_zero_request();
        write_request('0);
        send_item(ACT_START, '1);      // sample field of a start is ignored
        for (int i = 0; i < ROUND_LEN; i++)
            send_item(ACT_SAMPLE, (i % 2 == 1) ? 10'h3FF : 10'h000);
        send_item(ACT_SAMPLE, 10'h3FF);
        drain_results();
    endtask

    // Requests shorter than a burst: tlast and done land on the same byte.
    task automatic test_short_requests();
        write_request(16'd1);
        send_item(ACT_START, 10'h155);
        send_round(ROUND_LEN);
        send_round(3);                 // after completion: ignored
        drain_results();
        write_request(16'd5);
        send_item(ACT_START, '0);
        send_round(ROUND_LEN);
        drain_results();
    endtask

    // Multi-round request, aborted once mid-round by a fresh start.
    task automatic test_round_carry();
        write_request(16'd40);
        send_item(ACT_START, '0);
        send_round(60);
        send_item(ACT_START, '1);      // clears pool and counters
        send_round(3 * ROUND_LEN);     // 16 + 16 + 8 bytes
        drain_results();
    endtask

    // Largest request: full bursts with done never set.
    task automatic test_max_request();
        write_request('1);
        send_item(ACT_START, 10'h2AA);
        send_round(2 * ROUND_LEN);
        drain_results();
    endtask

    // Mostly well-formed requests with random content; occasional stray starts.
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int phase_base;
        int n;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        phase_base         = bytes_predicted;
        do
        begin
            write_request(pick_request());
            send_item(ACT_START, noise_sample());
            n = $urandom_range(ROUND_LEN + 2, 3 * ROUND_LEN);
            repeat (n)
            begin
                if ($urandom_range(99) < 2)
                    send_item(ACT_START, noise_sample());
                else
                    send_item(ACT_SAMPLE, noise_sample());
            end
            drain_results();
        end
        while (bytes_predicted - phase_base < 24);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_samples();
        test_zero_request();
        test_short_requests();
        test_round_carry();
        test_max_request();

        test_random_phase(0, 0);
        test_random_phase(63, 0);
        test_random_phase(0, 63);
        test_random_phase(8, 8);

        drain_results();
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("adc_entropy_pool_harvester_unit regression: pass");
        else
            $display("adc_entropy_pool_harvester_unit regression: fail");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("adc_entropy_pool_harvester_unit regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/eph_pkg.sv
design/eph_cell.sv
design/adc_entropy_pool_harvester_unit.sv
design/eph_checker.sv
test/tb_adc_entropy_pool_harvester_unit.sv
